// ===== rtl/gecp_pkg.sv =====
// Package for the corner-preferring grid extrema core.
// Holds the shared constants, register indexes, the queue entry and status types and the clamp function.
// No dependencies.
package gecp_pkg;

  // Field widths.
  localparam int unsigned ValueW = 32;
  localparam int unsigned IndexW = 20;
  localparam int unsigned DimW   = 11;
  localparam int unsigned TolW   = 26;
  localparam int unsigned CfgIdxW = 2;

  // Largest grid side and the fixed corner margin (1000.0 less one LSB, in Q16.16).
  localparam logic [DimW-1:0] MaxGridDim = 11'd1024;
  localparam logic [TolW-1:0] ThousandQm1 = 26'd65535999;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgGridCols = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGridRows = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTolerance = 2'd2;

  // One classified grid value, as passed from the front to the back.
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [IndexW-1:0]        index;
    logic                     is_first;
    logic                     is_corner;
    logic                     is_last;
  } entry_t;

  // Status of the back part, for checking at the top level.
  typedef struct packed {
    logic pop;
    logic pop_last;
    logic fin_inner_seen;
  } back_status_t;

  // Clamp a dimension register to the range 1..MaxGridDim.
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] r);
    logic [DimW-1:0] res;
    if (r == '0) begin
      res = 11'd1;
    end else if (r > MaxGridDim) begin
      res = MaxGridDim;
    end else begin
      res = r;
    end
    return res;
  endfunction

endpackage

// ===== rtl/grid_extrema_corner_preference_core.sv =====
// Channel  | Handshake                    | Word
// ---------+------------------------------+-------------------------------------
// input    | in_valid_i / in_ready_o      | sample_value_i
// output   | out_valid_o / out_ready_i    | max/min value, index, from_corner
// config   | cfg_we_i (no wait)           | cfg_index_i, cfg_data_i
//
// One grid value is taken per cycle while in_ready_o is high. The front
// classifies a word as it is accepted and writes it into a two-entry queue;
// the back takes it at the next edge at the earliest, one word per cycle. The
// result is valid in the cycle after the back takes the last word of a grid
// and stays until taken. The next grid streams in meanwhile; only its last
// word waits on an untaken result, and once the queue fills behind it
// in_ready_o drops. Reset is asynchronous and active low.
//
// Top level of the corner-preferring grid extrema core.
// Depends on gecp_pkg, gecp_front, gecp_fifo and gecp_back.
module grid_extrema_corner_preference_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gecp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [gecp_pkg::TolW-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [gecp_pkg::ValueW-1:0] sample_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [gecp_pkg::ValueW-1:0] max_value_o,
  output logic [gecp_pkg::IndexW-1:0]        max_index_o,
  output logic                               max_from_corner_o,
  output logic signed [gecp_pkg::ValueW-1:0] min_value_o,
  output logic [gecp_pkg::IndexW-1:0]        min_index_o,
  output logic                               min_from_corner_o
);

  logic [gecp_pkg::DimW-1:0] grid_cols_q, grid_cols_d;
  logic [gecp_pkg::DimW-1:0] grid_rows_q, grid_rows_d;
  logic [gecp_pkg::TolW-1:0] tolerance_q, tolerance_d;

  logic                   push, fifo_full, fifo_valid, pop;
  gecp_pkg::entry_t       push_entry, head_entry;
  gecp_pkg::back_status_t back_status;

  // Configuration registers.
  always_comb begin
    grid_cols_d = grid_cols_q;
    grid_rows_d = grid_rows_q;
    tolerance_d = tolerance_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        gecp_pkg::CfgGridCols:  grid_cols_d = cfg_data_i[gecp_pkg::DimW-1:0];
        gecp_pkg::CfgGridRows:  grid_rows_d = cfg_data_i[gecp_pkg::DimW-1:0];
        gecp_pkg::CfgTolerance: tolerance_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= 11'd1;
      grid_rows_q <= 11'd1;
      tolerance_q <= '0;
    end else begin
      grid_cols_q <= grid_cols_d;
      grid_rows_q <= grid_rows_d;
      tolerance_q <= tolerance_d;
    end
  end

  // Input accepted whenever the queue has room.
  assign in_ready_o = !fifo_full;
  assign push       = in_valid_i && !fifo_full;

  gecp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .grid_cols_i    (grid_cols_q),
    .grid_rows_i    (grid_rows_q),
    .push_i         (push),
    .sample_value_i (sample_value_i),
    .entry_o        (push_entry)
  );

  gecp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .head_o      (head_entry)
  );

  gecp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .tolerance_i       (tolerance_q),
    .head_valid_i      (fifo_valid),
    .head_i            (head_entry),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .max_value_o       (max_value_o),
    .max_index_o       (max_index_o),
    .max_from_corner_o (max_from_corner_o),
    .min_value_o       (min_value_o),
    .min_index_o       (min_index_o),
    .min_from_corner_o (min_from_corner_o),
    .status_o          (back_status)
  );

`ifndef SYNTHESIS
  // A result only ever follows the last word of a grid.
  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(back_status.pop_last))
    else $error("result raised without a last grid word");

  // The back never takes a word from an empty queue.
  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.pop |-> fifo_valid)
    else $error("pop from empty queue");

  // Without an interior value both extrema come from the corners.
  a_no_inner_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !back_status.fin_inner_seen) |->
      (max_from_corner_o && min_from_corner_o))
    else $error("interior chosen with no interior value");

  // A last word is never taken while an untaken result is pending.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !back_status.pop_last)
    else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/gecp_front.sv =====
// Front part: counts grid positions and classifies each value.
// Depends on gecp_pkg.
module gecp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gecp_pkg::DimW-1:0]     grid_cols_i,
  input  logic [gecp_pkg::DimW-1:0]     grid_rows_i,
  input  logic                          push_i,
  input  logic signed [gecp_pkg::ValueW-1:0] sample_value_i,
  output gecp_pkg::entry_t              entry_o
);

  logic [gecp_pkg::IndexW-1:0] count_q, count_d;
  logic [gecp_pkg::DimW-1:0]   cols, rows;
  logic [2*gecp_pkg::DimW-1:0] prod;
  logic [gecp_pkg::IndexW-1:0] last_pos, third_pos, second_pos;
  logic                        is_last;

  // Grid geometry from the live configuration.
  always_comb begin
    cols       = gecp_pkg::clamp_dim(grid_cols_i);
    rows       = gecp_pkg::clamp_dim(grid_rows_i);
    prod       = {{gecp_pkg::DimW{1'b0}}, cols} * {{gecp_pkg::DimW{1'b0}}, rows};
    last_pos   = prod[gecp_pkg::IndexW-1:0] - 20'd1;
    third_pos  = prod[gecp_pkg::IndexW-1:0] -
                 {{(gecp_pkg::IndexW-gecp_pkg::DimW){1'b0}}, cols};
    second_pos = {{(gecp_pkg::IndexW-gecp_pkg::DimW){1'b0}}, cols - 11'd1};
  end

  // Classify the current position.
  always_comb begin
    is_last            = (count_q >= last_pos);
    entry_o.value      = sample_value_i;
    entry_o.index      = count_q;
    entry_o.is_first   = (count_q == '0);
    entry_o.is_last    = is_last;
    entry_o.is_corner  = (count_q == '0) || (count_q == second_pos) ||
                         (count_q == third_pos) || is_last;
  end

  // Position counter restarts after the last element of a grid.
  always_comb begin
    count_d = count_q;
    if (push_i) begin
      count_d = is_last ? '0 : count_q + 20'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/gecp_fifo.sv =====
// Two-entry queue between the front and the back part.
// Depends on gecp_pkg.
module gecp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gecp_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output gecp_pkg::entry_t head_o
);

  gecp_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o  = fill_q[1];
  assign valid_o = (fill_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Storage for the queued words.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/gecp_back.sv =====
// Back part: keeps corner and interior extrema and forms the result.
// Depends on gecp_pkg.
module gecp_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [gecp_pkg::TolW-1:0]        tolerance_i,
  input  logic                             head_valid_i,
  input  gecp_pkg::entry_t                 head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [gecp_pkg::ValueW-1:0] max_value_o,
  output logic [gecp_pkg::IndexW-1:0]      max_index_o,
  output logic                             max_from_corner_o,
  output logic signed [gecp_pkg::ValueW-1:0] min_value_o,
  output logic [gecp_pkg::IndexW-1:0]      min_index_o,
  output logic                             min_from_corner_o,
  output gecp_pkg::back_status_t           status_o
);

  // Running extrema.
  logic signed [gecp_pkg::ValueW-1:0] cmax_v_q, cmax_v_d, cmin_v_q, cmin_v_d;
  logic signed [gecp_pkg::ValueW-1:0] imax_v_q, imax_v_d, imin_v_q, imin_v_d;
  logic [gecp_pkg::IndexW-1:0]        cmax_i_q, cmax_i_d, cmin_i_q, cmin_i_d;
  logic [gecp_pkg::IndexW-1:0]        imax_i_q, imax_i_d, imin_i_q, imin_i_d;
  logic                               seen_q, seen_d;

  // Result register, loaded with the final extrema of a grid.
  logic                               fin_valid_q, fin_valid_d;
  logic signed [gecp_pkg::ValueW-1:0] f_cmax_v_q, f_cmin_v_q, f_imax_v_q, f_imin_v_q;
  logic [gecp_pkg::IndexW-1:0]        f_cmax_i_q, f_cmin_i_q, f_imax_i_q, f_imin_i_q;
  logic                               f_seen_q;

  logic                               pop_last;
  logic [gecp_pkg::TolW-1:0]          thr;
  logic signed [gecp_pkg::ValueW:0]   dmax, dmin;
  logic                               cmax_wins, cmin_wins;

  // A last word waits while an undelivered result occupies the output.
  assign pop_o    = head_valid_i &&
                    (!head_i.is_last || !fin_valid_q || out_ready_i);
  assign pop_last = pop_o && head_i.is_last;

  // Update the extrema with one word.
  always_comb begin
    cmax_v_d = cmax_v_q;  cmax_i_d = cmax_i_q;
    cmin_v_d = cmin_v_q;  cmin_i_d = cmin_i_q;
    imax_v_d = imax_v_q;  imax_i_d = imax_i_q;
    imin_v_d = imin_v_q;  imin_i_d = imin_i_q;
    seen_d   = seen_q;
    if (pop_o) begin
      priority if (head_i.is_first) begin
        cmax_v_d = head_i.value;  cmax_i_d = '0;
        cmin_v_d = head_i.value;  cmin_i_d = '0;
      end else if (head_i.is_corner) begin
        if (head_i.value > cmax_v_q) begin
          cmax_v_d = head_i.value;  cmax_i_d = head_i.index;
        end
        if (head_i.value < cmin_v_q) begin
          cmin_v_d = head_i.value;  cmin_i_d = head_i.index;
        end
      end else if (!seen_q) begin
        imax_v_d = head_i.value;  imax_i_d = head_i.index;
        imin_v_d = head_i.value;  imin_i_d = head_i.index;
        seen_d   = 1'b1;
      end else begin
        if (head_i.value > imax_v_q) begin
          imax_v_d = head_i.value;  imax_i_d = head_i.index;
        end
        if (head_i.value < imin_v_q) begin
          imin_v_d = head_i.value;  imin_i_d = head_i.index;
        end
      end
      // The next grid starts with no interior value.
      if (head_i.is_last) begin
        seen_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmax_v_q <= cmax_v_d;  cmax_i_q <= cmax_i_d;
    cmin_v_q <= cmin_v_d;  cmin_i_q <= cmin_i_d;
    imax_v_q <= imax_v_d;  imax_i_q <= imax_i_d;
    imin_v_q <= imin_v_d;  imin_i_q <= imin_i_d;
  end

  // Output valid: set by a last word, cleared when the result is taken.
  always_comb begin
    fin_valid_d = fin_valid_q;
    if (pop_last) begin
      fin_valid_d = 1'b1;
    end else if (out_ready_i) begin
      fin_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else begin
      fin_valid_q <= fin_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_last) begin
      f_cmax_v_q <= cmax_v_d;  f_cmax_i_q <= cmax_i_d;
      f_cmin_v_q <= cmin_v_d;  f_cmin_i_q <= cmin_i_d;
      f_imax_v_q <= imax_v_q;  f_imax_i_q <= imax_i_q;
      f_imin_v_q <= imin_v_q;  f_imin_i_q <= imin_i_q;
      f_seen_q   <= seen_q;
    end
  end

  // The corner wins if it leads by more than the smaller of the tolerance
  // and the fixed margin, or if there is no interior value at all.
  always_comb begin
    thr  = (tolerance_i > gecp_pkg::ThousandQm1) ? gecp_pkg::ThousandQm1 : tolerance_i;
    dmax = {f_cmax_v_q[gecp_pkg::ValueW-1], f_cmax_v_q} -
           {f_imax_v_q[gecp_pkg::ValueW-1], f_imax_v_q};
    dmin = {f_imin_v_q[gecp_pkg::ValueW-1], f_imin_v_q} -
           {f_cmin_v_q[gecp_pkg::ValueW-1], f_cmin_v_q};
    cmax_wins = !f_seen_q || (!dmax[gecp_pkg::ValueW] &&
                (dmax[gecp_pkg::ValueW-1:0] >
                 {{(gecp_pkg::ValueW-gecp_pkg::TolW){1'b0}}, thr}));
    cmin_wins = !f_seen_q || (!dmin[gecp_pkg::ValueW] &&
                (dmin[gecp_pkg::ValueW-1:0] >
                 {{(gecp_pkg::ValueW-gecp_pkg::TolW){1'b0}}, thr}));
  end

  assign out_valid_o       = fin_valid_q;
  assign max_value_o       = cmax_wins ? f_cmax_v_q : f_imax_v_q;
  assign max_index_o       = cmax_wins ? f_cmax_i_q : f_imax_i_q;
  assign max_from_corner_o = cmax_wins;
  assign min_value_o       = cmin_wins ? f_cmin_v_q : f_imin_v_q;
  assign min_index_o       = cmin_wins ? f_cmin_i_q : f_imin_i_q;
  assign min_from_corner_o = cmin_wins;

  assign status_o.pop            = pop_o;
  assign status_o.pop_last       = pop_last;
  assign status_o.fin_inner_seen = f_seen_q;

endmodule

// ===== dv/grid_extrema_corner_preference_core_test.sv =====
// Self-checking testbench for the corner-preferring grid extrema core.
// Streams grids through the core and checks every result word against a predictor.
// Depends on gecp_pkg and grid_extrema_corner_preference_core.
module grid_extrema_corner_preference_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SettleCycles = 10;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned NumPhases    = 24;
  localparam int unsigned PhaseItems   = 58;
  localparam int unsigned HoldPhase    = 4;
  localparam int unsigned MaxReports   = 10;

  // Index 3 is not a register; writes to it must be ignored.
  localparam logic [gecp_pkg::CfgIdxW-1:0] CfgSpare  = 2'd3;
  localparam logic [gecp_pkg::TolW-1:0]    TolAllOnes = 26'h3FFFFFF;

  // One result word: both chosen extremes.
  typedef struct packed {
    logic signed [gecp_pkg::ValueW-1:0] max_value;
    logic [gecp_pkg::IndexW-1:0]        max_index;
    logic                               max_corner;
    logic signed [gecp_pkg::ValueW-1:0] min_value;
    logic [gecp_pkg::IndexW-1:0]        min_index;
    logic                               min_corner;
  } extrema_t;

  // Kinds of value sets used to fill one grid.
  typedef enum int unsigned {MixWide, MixNear, MixMargin, MixEdge} value_mix_e;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [gecp_pkg::CfgIdxW-1:0]       cfg_index_i;
  logic [gecp_pkg::TolW-1:0]          cfg_data_i;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic signed [gecp_pkg::ValueW-1:0] sample_value_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic signed [gecp_pkg::ValueW-1:0] max_value_o;
  logic [gecp_pkg::IndexW-1:0]        max_index_o;
  logic                               max_from_corner_o;
  logic signed [gecp_pkg::ValueW-1:0] min_value_o;
  logic [gecp_pkg::IndexW-1:0]        min_index_o;
  logic                               min_from_corner_o;

  grid_extrema_corner_preference_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_value_i    (sample_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .max_value_o       (max_value_o),
    .max_index_o       (max_index_o),
    .max_from_corner_o (max_from_corner_o),
    .min_value_o       (min_value_o),
    .min_index_o       (min_index_o),
    .min_from_corner_o (min_from_corner_o)
  );

  // Grid values waiting to be offered, and result words still owed by the core.
  logic [gecp_pkg::ValueW-1:0] sample_backlog_q[$];
  extrema_t                    expected_extrema_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  bit          in_taken = 0;

  // Predictor copy of the registers and the running grid state.
  logic [gecp_pkg::DimW-1:0]          cols_cfg = 11'd1;
  logic [gecp_pkg::DimW-1:0]          rows_cfg = 11'd1;
  logic [gecp_pkg::TolW-1:0]          tol_cfg = '0;
  int unsigned                        elem_count = 0;
  logic signed [gecp_pkg::ValueW-1:0] corner_hi, corner_lo, inner_hi, inner_lo;
  logic [gecp_pkg::IndexW-1:0]        corner_hi_at, corner_lo_at, inner_hi_at, inner_lo_at;
  bit                                 inner_seen = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // A side register of zero counts as one; anything above the maximum is clamped.
  function automatic int unsigned side_len(input logic [gecp_pkg::DimW-1:0] r);
    if (r == '0) begin
      return 1;
    end
    if (r > gecp_pkg::MaxGridDim) begin
      return 32'(gecp_pkg::MaxGridDim);
    end
    return 32'(r);
  endfunction

  // True when a exceeds b by strictly more than the margin.
  function automatic bit outruns(input logic signed [gecp_pkg::ValueW-1:0] a,
                                 input logic signed [gecp_pkg::ValueW-1:0] b,
                                 input longint margin);
    return (longint'(a) - longint'(b)) > margin;
  endfunction

  function automatic void clear_grid_state();
    elem_count = 0;
    corner_hi = '0;
    corner_lo = '0;
    inner_hi = '0;
    inner_lo = '0;
    corner_hi_at = '0;
    corner_lo_at = '0;
    inner_hi_at = '0;
    inner_lo_at = '0;
    inner_seen = 0;
  endfunction

  // Folds one grid value into the kept extremes; returns 1 with the result
  // word when the value closes the grid.
  function automatic bit absorb_grid_value(input logic signed [gecp_pkg::ValueW-1:0] v,
                                           output extrema_t res);
    int unsigned cols, rows, last, idx;
    bit          is_last, corner, hi_corner, lo_corner;
    res = '0;
    cols = side_len(cols_cfg);
    rows = side_len(rows_cfg);
    last = cols * rows - 1;
    idx = elem_count;
    is_last = idx >= last;
    corner = (idx == 0) || (idx == cols - 1) || (idx == cols * (rows - 1)) || is_last;
    if (idx == 0) begin
      corner_hi = v;
      corner_lo = v;
      corner_hi_at = '0;
      corner_lo_at = '0;
    end else if (corner) begin
      if (v > corner_hi) begin
        corner_hi = v;
        corner_hi_at = gecp_pkg::IndexW'(idx);
      end
      if (v < corner_lo) begin
        corner_lo = v;
        corner_lo_at = gecp_pkg::IndexW'(idx);
      end
    end else if (!inner_seen) begin
      inner_hi = v;
      inner_lo = v;
      inner_hi_at = gecp_pkg::IndexW'(idx);
      inner_lo_at = gecp_pkg::IndexW'(idx);
      inner_seen = 1;
    end else begin
      if (v > inner_hi) begin
        inner_hi = v;
        inner_hi_at = gecp_pkg::IndexW'(idx);
      end
      if (v < inner_lo) begin
        inner_lo = v;
        inner_lo_at = gecp_pkg::IndexW'(idx);
      end
    end
    if (!is_last) begin
      elem_count = idx + 1;
      return 0;
    end
    // The corner wins with no interior, past the tolerance, or by 1000.0 or more.
    hi_corner = !inner_seen || outruns(corner_hi, inner_hi, tol_cfg) ||
                outruns(corner_hi, inner_hi, gecp_pkg::ThousandQm1);
    lo_corner = !inner_seen || outruns(inner_lo, corner_lo, tol_cfg) ||
                outruns(inner_lo, corner_lo, gecp_pkg::ThousandQm1);
    res.max_value  = hi_corner ? corner_hi : inner_hi;
    res.max_index  = hi_corner ? corner_hi_at : inner_hi_at;
    res.max_corner = hi_corner;
    res.min_value  = lo_corner ? corner_lo : inner_lo;
    res.min_index  = lo_corner ? corner_lo_at : inner_lo_at;
    res.min_corner = lo_corner;
    clear_grid_state();
    return 1;
  endfunction

  task automatic note_mismatch(input string what, input extrema_t want, input extrema_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t: %s: expected max %0d @%0d corner %0b min %0d @%0d corner %0b", $time,
               what, want.max_value, want.max_index, want.max_corner, want.min_value,
               want.min_index, want.min_corner);
      $display("%0t: %s: actual   max %0d @%0d corner %0b min %0d @%0d corner %0b", $time,
               what, got.max_value, got.max_index, got.max_corner, got.min_value,
               got.min_index, got.min_corner);
    end
  endtask

  // Monitor: register writes, result checks, input predictions and the watchdog.
  always @(posedge clk_i) begin
    extrema_t got;
    extrema_t want;
    bit       progress;
    progress = 0;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          gecp_pkg::CfgGridCols:  cols_cfg = cfg_data_i[gecp_pkg::DimW-1:0];
          gecp_pkg::CfgGridRows:  rows_cfg = cfg_data_i[gecp_pkg::DimW-1:0];
          gecp_pkg::CfgTolerance: tol_cfg = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        progress = 1;
        got.max_value  = max_value_o;
        got.max_index  = max_index_o;
        got.max_corner = max_from_corner_o;
        got.min_value  = min_value_o;
        got.min_index  = min_index_o;
        got.min_corner = min_from_corner_o;
        if (expected_extrema_q.size() == 0) begin
          note_mismatch("unexpected result word", '0, got);
        end else begin
          want = expected_extrema_q.pop_front();
          if (got.max_value !== want.max_value || got.max_index !== want.max_index ||
              got.max_corner !== want.max_corner || got.min_value !== want.min_value ||
              got.min_index !== want.min_index || got.min_corner !== want.min_corner) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
      in_taken = in_valid_i && in_ready_o;
      if (in_taken) begin
        progress = 1;
        if (absorb_grid_value(sample_value_i, want)) begin
          expected_extrema_q.push_back(want);
        end
      end
      // Only count cycles in which work is outstanding and nothing moves.
      if (progress || (sample_backlog_q.size() == 0 && !in_valid_i &&
                       expected_extrema_q.size() == 0)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, StallLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Driver: offers the next grid value, holding it until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (sample_backlog_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_value_i <= sample_backlog_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [gecp_pkg::CfgIdxW-1:0] idx,
                           input logic [gecp_pkg::TolW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_grid(input logic [gecp_pkg::DimW-1:0] cols,
                          input logic [gecp_pkg::DimW-1:0] rows,
                          input logic [gecp_pkg::TolW-1:0] tol);
    write_reg(gecp_pkg::CfgGridCols, gecp_pkg::TolW'(cols));
    write_reg(gecp_pkg::CfgGridRows, gecp_pkg::TolW'(rows));
    write_reg(gecp_pkg::CfgTolerance, tol);
  endtask

  // Waits until every value is taken and every result word is back, then lets
  // the pipeline settle so a register write cannot hit a word in flight.
  task automatic wait_for_drain();
    while (sample_backlog_q.size() != 0 || in_valid_i) begin
      @(negedge clk_i);
    end
    while (expected_extrema_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [gecp_pkg::ValueW-1:0] grid_sample(
      input value_mix_e mix,
      input logic [gecp_pkg::ValueW-1:0] base,
      input logic [gecp_pkg::TolW-1:0] tol);
    logic [gecp_pkg::ValueW-1:0] t;
    logic [gecp_pkg::ValueW-1:0] step;
    t = gecp_pkg::ValueW'(tol);
    case (mix)
      MixWide: return $urandom;
      MixNear: return base + $urandom_range(0, 3);
      MixMargin: begin
        // Offsets that land right on the tolerance and the 1000.0 margin.
        case ($urandom_range(0, 9))
          0: step = '0;
          1: step = t;
          2: step = -t;
          3: step = t + 1;
          4: step = -(t + 1);
          5: step = 32'd65535999;
          6: step = -32'd65535999;
          7: step = 32'd65536000;
          8: step = -32'd65536000;
          default: step = 32'd65536001;
        endcase
        return base + step;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFFFFFF;
          1: return 32'h80000000;
          2: return '0;
          default: return 32'hFFFFFFFF;
        endcase
      end
    endcase
  endfunction

  task automatic queue_grid(input int unsigned n_items, input logic [gecp_pkg::TolW-1:0] tol);
    value_mix_e                  mix;
    logic [gecp_pkg::ValueW-1:0] base;
    mix = value_mix_e'($urandom_range(0, 3));
    base = $urandom_range(0, 32'h7FFFFFFF) - 32'h40000000;
    for (int k = 0; k < n_items; k++) begin
      sample_backlog_q.push_back(grid_sample(mix, base, tol));
    end
  endtask

  function automatic logic [gecp_pkg::DimW-1:0] pick_side();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) begin
      return '0;
    end else if (r < 20) begin
      return 11'd1;
    end else if (r < 28) begin
      return gecp_pkg::DimW'($urandom_range(7, 12));
    end
    return gecp_pkg::DimW'($urandom_range(2, 6));
  endfunction

  function automatic logic [gecp_pkg::TolW-1:0] pick_tolerance(input int unsigned phase);
    case (phase)
      0: return '0;
      1: return 26'd65535999;
      2: return 26'd65536000;
      3: return TolAllOnes;
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return gecp_pkg::TolW'($urandom_range(0, 255));
          2: return gecp_pkg::TolW'($urandom_range(0, 1 << 20));
          default: return gecp_pkg::TolW'($urandom);
        endcase
      end
    endcase
  endfunction

  // Stimulus: directed grids first, then random phases with varied idling.
  initial begin
    logic [gecp_pkg::DimW-1:0] cols;
    logic [gecp_pkg::DimW-1:0] rows;
    logic [gecp_pkg::TolW-1:0] tol;
    int unsigned               grid_len;
    int unsigned               queued;
    int unsigned               n;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = gecp_pkg::CfgGridCols;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_value_i = '0;
    out_ready_i = 1'b0;
    clear_grid_state();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Single element grids under the reset sizes: each value is its own corner.
    sample_backlog_q.push_back(32'h7FFFFFFF);
    sample_backlog_q.push_back(32'h80000000);
    wait_for_drain();

    // A 3x3 grid with ties on both sides and extremes near the tolerance.
    set_grid(11'd3, 11'd3, 26'd10);
    sample_backlog_q.push_back(32'd100);
    sample_backlog_q.push_back(32'd110);
    sample_backlog_q.push_back(32'd100);
    sample_backlog_q.push_back(-32'd5);
    sample_backlog_q.push_back(32'd110);
    sample_backlog_q.push_back(-32'd5);
    sample_backlog_q.push_back(32'd121);
    sample_backlog_q.push_back(-32'd20);
    sample_backlog_q.push_back(-32'd9);
    wait_for_drain();

    // One column, tolerance above 1000.0: the corner still wins past the margin.
    set_grid(11'd1, 11'd3, 26'd65536000);
    sample_backlog_q.push_back(32'd0);
    sample_backlog_q.push_back(-32'd65536000);
    sample_backlog_q.push_back(32'd0);
    wait_for_drain();

    // Out-of-range sizes, then a shrink mid-grid that makes the next value last.
    set_grid(11'd0, 11'd2047, TolAllOnes);
    sample_backlog_q.push_back(32'h12345678);
    sample_backlog_q.push_back(32'hEDCBA987);
    wait_for_drain();
    write_reg(gecp_pkg::CfgGridCols, gecp_pkg::TolW'(11'd2));
    write_reg(gecp_pkg::CfgGridRows, '0);
    sample_backlog_q.push_back(32'h00000001);
    wait_for_drain();
    write_reg(CfgSpare, TolAllOnes);

    for (int p = 0; p < NumPhases; p++) begin
      cols = pick_side();
      rows = pick_side();
      tol = pick_tolerance(p);
      if (p == HoldPhase) begin
        // Small grids keep results coming, so the hold-off backs up the input.
        cols = 11'd2;
        rows = 11'd2;
      end
      set_grid(cols, rows, tol);
      send_idle_pct = (p % 4 == 1) ? 46 : (p % 4 == 3) ? 31 : 0;
      recv_stall_pct = (p % 4 == 2) ? 46 : (p % 4 == 3) ? 31 : 0;
      if (p == HoldPhase) begin
        hold_requests++;
      end
      grid_len = side_len(cols) * side_len(rows);
      queued = 0;
      // Whole grids back to back; sometimes the last one is cut short so the
      // next size change lands mid-grid.
      while (queued < PhaseItems) begin
        n = grid_len;
        if (queued + n >= PhaseItems && $urandom_range(3) == 0) begin
          n = $urandom_range(1, n);
        end
        queue_grid(n, tol);
        queued += n;
      end
      wait_for_drain();
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
